### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/pbfs_pkg.sv
// Types and constants of the piece block to file segment mapper.
package pbfs_pkg;

	localparam int SIZE_W  = 36;
	localparam int TOTAL_W = 40;
	localparam int ADDR_W  = 50;
	localparam int CFG_W   = 25;
	localparam int PL_W    = 25;
	localparam int FC_W    = 5;
	localparam int LEN_W   = 24;

	localparam logic REG_PIECE_LENGTH = 1'b0;
	localparam logic REG_FILE_COUNT   = 1'b1;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [3:0]        entry_index;
		logic [SIZE_W-1:0] entry_size;
		logic              access_op;
		logic [LEN_W-1:0]  piece_number;
		logic [LEN_W-1:0]  begin_offset;
		logic [LEN_W-1:0]  block_length;
	} in_t;

	typedef struct packed {
		logic [3:0]        seg_file;
		logic [SIZE_W-1:0] seg_file_offset;
		logic [LEN_W-1:0]  seg_length;
		logic [LEN_W-1:0]  seg_buffer_offset;
		logic              seg_op;
		logic              seg_last;
		logic              seg_error;
	} out_t;

	// Write of one size entry into the cell row.
	typedef struct packed {
		logic              we;
		logic [3:0]        index;
		logic [SIZE_W-1:0] size;
	} load_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_ADD   = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_WALK  = 5'b10000
	} state_t;

endpackage

### sv/pbfs_cell.sv
// One cell of the row: holds a file size and the stream end of its file.
module pbfs_cell #(
	parameter int INDEX = 0,
	parameter int POS_W = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pbfs_pkg::load_t    load,
	input  logic               in_use,
	input  logic [POS_W-1:0]   prev_end,
	output logic [POS_W-1:0]   cell_end
);

	logic [pbfs_pkg::SIZE_W-1:0] size_q;
	logic [POS_W-1:0]            end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			end_q  <= '0;
		end else begin
			if (load.we && (32'(load.index) == INDEX)) begin
				size_q <= load.size;
			end
			// unused files add nothing, so the last cell carries the total
			end_q <= prev_end + (in_use ? POS_W'(size_q) : '0);
		end
	end

	assign cell_end = end_q;

endmodule

### sv/pbfs_chain.sv
// Row of size cells that ripples the running stream end from cell to cell.
module pbfs_chain #(
	parameter int MAX_FILES = 16,
	parameter int POS_W     = 40,
	parameter int CNT_W     = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pbfs_pkg::load_t                  load,
	input  logic [CNT_W-1:0]                 files_used,
	output logic [MAX_FILES-1:0][POS_W-1:0]  cell_end
);

	for (genvar i = 0; i < MAX_FILES; i++) begin : g_cell
		logic [POS_W-1:0] prev;
		if (i == 0) begin : g_first
			assign prev = '0;
		end else begin : g_next
			assign prev = cell_end[i-1];
		end

		pbfs_cell #(
			.INDEX (i),
			.POS_W (POS_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (load),
			.in_use   (CNT_W'(i) < files_used),
			.prev_end (prev),
			.cell_end (cell_end[i])
		);
	end

endmodule

### sv/piece_block_to_file_segments.sv
// Top level of the piece block to file segment mapper.
//
// Input channel in_valid/in_ready/in_data carries two kinds of item. A load
// transfer writes one file size into the cell row; it gives no result and
// drops in_ready while the running stream ends ripple down the row, one
// cell per cycle. A write of file_count on the cfg_we port starts the same
// settling window.
// A request transfer maps one block onto the files: the product
// piece_number * piece_length, the start and end adds and the range check
// run in the states ST_MUL, ST_ADD and ST_CHECK, then the walk visits one
// table entry per cycle unless a segment waits for a full output register,
// up to the file that holds the end of the block. A request emits one
// result per file crossed (error and empty requests emit one).
// Results leave through an output register on out_valid/out_ready; the
// walk holds while that register is full and not taken, and the next item
// is accepted while the final result still waits. Reset clears the size
// table, restores piece_length 262144 and file_count 1, and empties the
// output register.
module piece_block_to_file_segments #(
	parameter int MAX_FILES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pbfs_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pbfs_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [pbfs_pkg::CFG_W-1:0]    cfg_data
);

	localparam int IDX_W  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int CNT_W  = $clog2(MAX_FILES + 1);
	localparam int POS_W  = pbfs_pkg::SIZE_W + $clog2(MAX_FILES);
	localparam int SET_W  = $clog2(MAX_FILES + 2);
	localparam int ADDR_W = pbfs_pkg::ADDR_W;
	localparam int LEN_W  = pbfs_pkg::LEN_W;

	// Configuration registers.
	logic [pbfs_pkg::PL_W-1:0] piece_len_q;
	logic [pbfs_pkg::FC_W-1:0] file_count_q;
	logic [CNT_W-1:0]          files_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_len_q  <= 25'd262144;
			file_count_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				pbfs_pkg::REG_PIECE_LENGTH: piece_len_q  <= cfg_data;
				pbfs_pkg::REG_FILE_COUNT:   file_count_q <= cfg_data[pbfs_pkg::FC_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the file count to the table depth.
	assign files_used = (32'(file_count_q) > MAX_FILES) ? CNT_W'(MAX_FILES)
	                                                    : CNT_W'(file_count_q);

	// Cell row.
	pbfs_pkg::state_t                state_q;
	logic                            in_acc;
	pbfs_pkg::load_t                 load;
	logic [MAX_FILES-1:0][POS_W-1:0] cell_end;
	logic [pbfs_pkg::TOTAL_W-1:0]    total;

	assign in_acc     = in_valid && in_ready;
	assign load.we    = in_acc && (in_data.kind == pbfs_pkg::KIND_LOAD);
	assign load.index = in_data.entry_index;
	assign load.size  = in_data.entry_size;

	pbfs_chain #(
		.MAX_FILES (MAX_FILES),
		.POS_W     (POS_W),
		.CNT_W     (CNT_W)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.files_used (files_used),
		.cell_end   (cell_end)
	);

	// The last cell carries the sum of the files in use.
	assign total = pbfs_pkg::TOTAL_W'(cell_end[MAX_FILES-1]);

	// Settling window after a size load or a file count write.
	logic [SET_W-1:0] settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= '0;
		end else if (load.we || (cfg_we && (cfg_index == pbfs_pkg::REG_FILE_COUNT))) begin
			settle_q <= SET_W'(MAX_FILES + 1);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	assign in_ready = (state_q == pbfs_pkg::ST_IDLE) && (settle_q == '0);

	// Request registers.
	logic              op_q;
	logic [LEN_W-1:0]  pn_q;
	logic [LEN_W-1:0]  bo_q;
	logic [LEN_W-1:0]  bl_q;
	logic [ADDR_W-1:0] base_s1;
	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] end_q;
	logic              bad_base_q;
	logic [ADDR_W-1:0] cur_q;
	logic [POS_W-1:0]  pos_q;
	logic [IDX_W-1:0]  idx_q;

	// Output register.
	logic           out_valid_q;
	pbfs_pkg::out_t out_q;
	logic           out_free;

	assign out_free = !out_valid_q || out_ready;

	// Range check and walk step.
	logic              need_emit;
	logic              bad_req;
	logic [ADDR_W-1:0] fend_sel;
	logic              hit;
	logic [ADDR_W-1:0] rem_file;
	logic [ADDR_W-1:0] rem_blk;
	logic              is_last;
	logic [ADDR_W-1:0] take;
	logic              idx_end;
	logic              emit;
	pbfs_pkg::out_t    res;

	assign bad_req   = bad_base_q ||
	                   ((bl_q != '0) && (end_q > ADDR_W'(total)));
	assign need_emit = bad_req || (bl_q == '0);

	assign fend_sel = ADDR_W'(cell_end[idx_q]);
	assign hit      = cur_q < fend_sel;
	assign rem_file = fend_sel - cur_q;
	assign rem_blk  = end_q - cur_q;
	assign is_last  = rem_file >= rem_blk;
	assign take     = is_last ? rem_blk : rem_file;
	assign idx_end  = (CNT_W'(idx_q) + CNT_W'(1)) >= files_used;

	always_comb begin
		emit                  = 1'b0;
		res.seg_file          = '0;
		res.seg_file_offset   = '0;
		res.seg_length        = '0;
		res.seg_buffer_offset = '0;
		res.seg_op            = op_q;
		res.seg_last          = 1'b1;
		res.seg_error         = 1'b0;
		case (state_q)
			pbfs_pkg::ST_CHECK: begin
				emit          = need_emit && out_free;
				res.seg_error = bad_req;
			end
			pbfs_pkg::ST_WALK: begin
				emit                  = hit && out_free;
				res.seg_file          = 4'(idx_q);
				res.seg_file_offset   = pbfs_pkg::SIZE_W'(cur_q - ADDR_W'(pos_q));
				res.seg_length        = LEN_W'(take);
				res.seg_buffer_offset = LEN_W'(cur_q - start_q);
				res.seg_last          = is_last;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbfs_pkg::ST_IDLE;
		end else begin
			case (state_q)
				pbfs_pkg::ST_IDLE: begin
					if (in_acc && (in_data.kind == pbfs_pkg::KIND_REQUEST)) begin
						state_q <= pbfs_pkg::ST_MUL;
					end
				end
				pbfs_pkg::ST_MUL:   state_q <= pbfs_pkg::ST_ADD;
				pbfs_pkg::ST_ADD:   state_q <= pbfs_pkg::ST_CHECK;
				pbfs_pkg::ST_CHECK: begin
					if (!need_emit) begin
						state_q <= pbfs_pkg::ST_WALK;
					end else if (out_free) begin
						state_q <= pbfs_pkg::ST_IDLE;
					end
				end
				pbfs_pkg::ST_WALK: begin
					if ((!hit || out_free) && ((hit && is_last) || idx_end)) begin
						state_q <= pbfs_pkg::ST_IDLE;
					end
				end
				default: state_q <= pbfs_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			pbfs_pkg::ST_IDLE: begin
				if (in_acc) begin
					op_q <= in_data.access_op;
					pn_q <= in_data.piece_number;
					bo_q <= in_data.begin_offset;
					bl_q <= in_data.block_length;
				end
			end
			pbfs_pkg::ST_MUL: begin
				base_s1 <= ADDR_W'(pn_q) * ADDR_W'(piece_len_q);
			end
			pbfs_pkg::ST_ADD: begin
				start_q    <= base_s1 + ADDR_W'(bo_q);
				end_q      <= base_s1 + ADDR_W'(bo_q) + ADDR_W'(bl_q);
				bad_base_q <= base_s1 >= ADDR_W'(total);
			end
			pbfs_pkg::ST_CHECK: begin
				cur_q <= start_q;
				pos_q <= '0;
				idx_q <= '0;
			end
			pbfs_pkg::ST_WALK: begin
				// advance past the file unless a segment waits for the output
				if (!hit || out_free) begin
					if (hit) begin
						cur_q <= cur_q + take;
					end
					pos_q <= POS_W'(fend_sel);
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### sv/pbfs_checker.sv
// Port-level checker of the segment mapper and its bind to the top level.
`include "assert_macros.svh"

module pbfs_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  pbfs_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  pbfs_pkg::out_t out_data
);

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// an error result closes its request and carries no bytes
	`ASSERT_IMPLY(a_err_last, clk, arst_n, out_valid && out_data.seg_error, out_data.seg_last && (out_data.seg_length == '0))

	// a segment that is not the last one covers at least one byte
	`ASSERT_IMPLY(a_mid_len, clk, arst_n, out_valid && !out_data.seg_last, (out_data.seg_length != '0) && !out_data.seg_error)

	// a size load closes the input while the row settles
	`ASSERT_NEXT(a_load_settle, clk, arst_n, in_valid && in_ready && (in_data.kind == pbfs_pkg::KIND_LOAD), !in_ready)

endmodule

bind piece_block_to_file_segments pbfs_checker u_pbfs_checker (.*);

### bench/piece_block_to_file_segments_test.sv
// Testbench for the piece block to file segment mapper: directed and random traffic.
`timescale 1ns / 100ps

module piece_block_to_file_segments_test;

	localparam int MAX_FILES     = 16;
	// The block must settle after a load and finish each request; wait a little
	// longer than either.
	localparam int SETTLE_CYCLES = MAX_FILES + 8;
	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_ITEMS  = 380;
	localparam longint unsigned LEN_MAX = 64'hFF_FFFF;

	typedef enum int {
		REQ_WELL,
		REQ_OVERRUN,
		REQ_NOISE
	} req_flavor_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	pbfs_pkg::in_t                 in_data;
	logic                          out_valid;
	logic                          out_ready;
	pbfs_pkg::out_t                out_data;
	logic                          cfg_we;
	logic                          cfg_index;
	logic [pbfs_pkg::CFG_W-1:0]    cfg_data;

	// Mirror of the block's state, updated at each accepted transfer or write.
	logic [pbfs_pkg::SIZE_W-1:0]   file_size [MAX_FILES];
	logic [pbfs_pkg::TOTAL_W-1:0]  stream_len;
	logic [pbfs_pkg::PL_W-1:0]     piece_len;
	logic [pbfs_pkg::FC_W-1:0]     files_used;

	pbfs_pkg::out_t      pending_segments [$];
	pbfs_pkg::out_t      seg_want;
	int                  fail_count  = 0;
	int                  idle_cycles = 0;
	int                  in_gap_max  = 12;
	int                  out_gap_max = 12;

	piece_block_to_file_segments #(
		.MAX_FILES(MAX_FILES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Segment prediction
	// ---------------------------------------------------------------

	function automatic longint unsigned lesser(longint unsigned a, longint unsigned b);
		return (a < b) ? a : b;
	endfunction

	// A file_count above the table depth counts as the whole table.
	function automatic longint unsigned files_in_use();
		return (files_used > MAX_FILES) ? MAX_FILES : files_used;
	endfunction

	// Sum only the entries in use; entries above file_count stay stored but idle.
	function automatic void refresh_stream_len();
		logic [pbfs_pkg::TOTAL_W-1:0] sum;
		sum = '0;
		for (int i = 0; i < files_in_use(); i++)
			sum += file_size[i];
		stream_len = sum;
	endfunction

	function automatic void push_segment(longint unsigned file, longint unsigned foff,
			longint unsigned len, longint unsigned boff, logic op, logic last, logic err);
		pbfs_pkg::out_t seg;
		seg.seg_file          = 4'(file);
		seg.seg_file_offset   = pbfs_pkg::SIZE_W'(foff);
		seg.seg_length        = pbfs_pkg::LEN_W'(len);
		seg.seg_buffer_offset = pbfs_pkg::LEN_W'(boff);
		seg.seg_op            = op;
		seg.seg_last          = last;
		seg.seg_error         = err;
		pending_segments.insert(pending_segments.size(), seg);
	endfunction

	// Split one block request into the segments of the files it crosses.
	function automatic void map_block(pbfs_pkg::in_t req);
		longint unsigned base, start, fin, cur, pos, fend, take;
		base = 64'(req.piece_number) * 64'(piece_len);
		// Piece index past the stream end: one error result.
		if (base >= stream_len) begin
			push_segment(0, 0, 0, 0, req.access_op, 1'b1, 1'b1);
			return;
		end
		// Empty block on a valid piece: one empty final result.
		if (req.block_length == '0) begin
			push_segment(0, 0, 0, 0, req.access_op, 1'b1, 1'b0);
			return;
		end
		start = base + req.begin_offset;
		fin   = start + req.block_length;
		// Block running past the stream end: one error result.
		if (fin > stream_len) begin
			push_segment(0, 0, 0, 0, req.access_op, 1'b1, 1'b1);
			return;
		end
		cur = start;
		pos = 0;
		// Walk the files in stream order; zero-size files never match cur < fend.
		for (int i = 0; i < files_in_use() && cur < fin; i++) begin
			fend = pos + file_size[i];
			if (cur < fend) begin
				take = lesser(fend - cur, fin - cur);
				push_segment(i, cur - pos, take, cur - start, req.access_op,
					(cur + take == fin), 1'b0);
				cur += take;
			end
			pos = fend;
		end
	endfunction

	function automatic void predict_item(pbfs_pkg::in_t item);
		if (item.kind == pbfs_pkg::KIND_LOAD) begin
			file_size[item.entry_index] = item.entry_size;
			refresh_stream_len();
		end else begin
			map_block(item);
		end
	endfunction

	// ---------------------------------------------------------------
	// Item builders
	// ---------------------------------------------------------------

	function automatic pbfs_pkg::in_t load_item(logic [3:0] slot,
			logic [pbfs_pkg::SIZE_W-1:0] size);
		pbfs_pkg::in_t it;
		it             = '0;
		it.kind        = pbfs_pkg::KIND_LOAD;
		it.entry_index = slot;
		it.entry_size  = size;
		return it;
	endfunction

	function automatic pbfs_pkg::in_t req_item(logic op, logic [pbfs_pkg::LEN_W-1:0] pn,
			logic [pbfs_pkg::LEN_W-1:0] bo, logic [pbfs_pkg::LEN_W-1:0] bl);
		pbfs_pkg::in_t it;
		it              = '0;
		it.kind         = pbfs_pkg::KIND_REQUEST;
		it.access_op    = op;
		it.piece_number = pn;
		it.begin_offset = bo;
		it.block_length = bl;
		return it;
	endfunction

	// Uniform from 0 up to hi, with extra weight on both ends.
	function automatic longint unsigned rand_upto(longint unsigned hi);
		longint unsigned r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return 0;
			1: return hi;
			default: return r % (hi + 1);
		endcase
	endfunction

	// Mostly small files so blocks cross many of them; some empty, a few huge.
	function automatic logic [pbfs_pkg::SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 9))
			0, 1: return '0;
			2: return pbfs_pkg::SIZE_W'({$urandom, $urandom});
			default: return pbfs_pkg::SIZE_W'($urandom_range(1, 300));
		endcase
	endfunction

	function automatic pbfs_pkg::in_t random_request(req_flavor_t flavor);
		logic [127:0] raw;
		pbfs_pkg::in_t it;
		longint unsigned top, base, room, start;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it  = raw[$bits(pbfs_pkg::in_t)-1:0];
		// Noise keeps every field random, the kind too.
		if (flavor == REQ_NOISE)
			return it;
		it.kind = pbfs_pkg::KIND_REQUEST;
		if (stream_len == '0)
			return it;
		// Aim inside the stream: pick a valid piece, then an offset before the end.
		base = 0;
		if (piece_len != '0) begin
			top = lesser((64'(stream_len) - 1) / piece_len, LEN_MAX);
			it.piece_number = pbfs_pkg::LEN_W'(rand_upto(top));
			base = 64'(it.piece_number) * 64'(piece_len);
		end
		room = stream_len - base;
		it.begin_offset = pbfs_pkg::LEN_W'(rand_upto(lesser(room - 1, LEN_MAX)));
		start = base + it.begin_offset;
		room  = stream_len - start;
		if (flavor == REQ_OVERRUN)
			it.block_length = pbfs_pkg::LEN_W'(lesser(room + 1, LEN_MAX));
		else
			it.block_length = pbfs_pkg::LEN_W'(rand_upto(lesser(room,
				$urandom_range(0, 1) ? 64 : LEN_MAX)));
		return it;
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// Hold valid and payload until the transfer; keep valid high on the way out
	// so a back-to-back item never drops it.
	task automatic send_item(input pbfs_pkg::in_t item);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		predict_item(item);
	endtask

	// Drop valid, wait for every expected segment, then let the settling window pass.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_segments.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [pbfs_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == pbfs_pkg::REG_PIECE_LENGTH) begin
			piece_len = value[pbfs_pkg::PL_W-1:0];
		end else begin
			files_used = value[pbfs_pkg::FC_W-1:0];
			refresh_stream_len();
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: draw a stall per result, then hold ready until a transfer.
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, out_gap_max);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic log_failure(input string what, input pbfs_pkg::out_t got,
			input pbfs_pkg::out_t want);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t %s: got file %0d foff %0d len %0d boff %0d op %0b last %0b err %0b",
				$realtime, what, got.seg_file, got.seg_file_offset, got.seg_length,
				got.seg_buffer_offset, got.seg_op, got.seg_last, got.seg_error);
			$display("    want file %0d foff %0d len %0d boff %0d op %0b last %0b err %0b",
				want.seg_file, want.seg_file_offset, want.seg_length,
				want.seg_buffer_offset, want.seg_op, want.seg_last, want.seg_error);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_segments.size() == 0) begin
				log_failure("segment with nothing expected", out_data, '0);
			end else begin
				seg_want = pending_segments.pop_front();
				if (out_data.seg_file !== seg_want.seg_file
						|| out_data.seg_file_offset !== seg_want.seg_file_offset
						|| out_data.seg_length !== seg_want.seg_length
						|| out_data.seg_buffer_offset !== seg_want.seg_buffer_offset
						|| out_data.seg_op !== seg_want.seg_op
						|| out_data.seg_last !== seg_want.seg_last
						|| out_data.seg_error !== seg_want.seg_error)
					log_failure("segment mismatch", out_data, seg_want);
			end
		end
	end

	// Watchdog: any transfer or register write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Run on the reset register values: empty stream first, then one file.
	task automatic test_reset_defaults();
		in_gap_max  = 12;
		out_gap_max = 12;
		send_item(req_item(1'b0, 24'd0, 24'd0, 24'd1));
		send_item(load_item(4'd0, 36'd600000));
		send_item(req_item(1'b1, 24'd1, 24'd0, 24'd1000));
		// Last byte of the stream, then one byte past it.
		send_item(req_item(1'b0, 24'd2, 24'd75711, 24'd1));
		send_item(req_item(1'b1, 24'd2, 24'd75711, 24'd2));
		// Slot outside file_count: stored but not part of the stream.
		send_item(load_item(4'd1, 36'd100));
		drain();
	endtask

	// Small pieces over a sparse table with empty files in between.
	task automatic test_segment_walk();
		in_gap_max  = 0;
		out_gap_max = 0;
		write_reg(pbfs_pkg::REG_PIECE_LENGTH, 25'd16);
		write_reg(pbfs_pkg::REG_FILE_COUNT, 25'd16);
		send_item(load_item(4'd0, 36'd7));
		send_item(load_item(4'd5, 36'd20));
		send_item(load_item(4'd15, 36'd9));
		// Whole stream: four segments, ending exactly at the stream end.
		send_item(req_item(1'b0, 24'd0, 24'd0, 24'd136));
		send_item(req_item(1'b1, 24'd8, 24'd7, 24'd1));
		send_item(req_item(1'b0, 24'd8, 24'd8, 24'd1));
		// Empty block on a valid piece, then on the first piece past the end.
		send_item(req_item(1'b1, 24'd8, 24'd8, 24'd0));
		send_item(req_item(1'b0, 24'd9, 24'd0, 24'd0));
		send_item(req_item(1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
		drain();

		// Zero piece length: every piece starts at the stream head.
		write_reg(pbfs_pkg::REG_PIECE_LENGTH, 25'd0);
		send_item(req_item(1'b0, 24'hFF_FFFF, 24'd6, 24'd2));
		drain();

		// No files in use: everything is past the end.
		write_reg(pbfs_pkg::REG_FILE_COUNT, 25'd0);
		send_item(req_item(1'b1, 24'd0, 24'd0, 24'd0));
		drain();

		// Widest piece, file_count above the table depth, largest file size.
		write_reg(pbfs_pkg::REG_PIECE_LENGTH, 25'h1FF_FFFF);
		write_reg(pbfs_pkg::REG_FILE_COUNT, 25'd31);
		send_item(load_item(4'd15, 36'hF_FFFF_FFFF));
		send_item(req_item(1'b0, 24'd1, 24'hFF_FFFF, 24'hFF_FFFF));
		drain();

		// Shrink the table so the huge last file drops out again.
		write_reg(pbfs_pkg::REG_PIECE_LENGTH, 25'd16);
		write_reg(pbfs_pkg::REG_FILE_COUNT, 25'd5);
		send_item(req_item(1'b1, 24'd6, 24'd4, 24'd7));
		drain();
	endtask

	// Phases of random settings: reload the table, then mostly in-range requests.
	task automatic test_random_traffic();
		int sent;
		int phase;
		int pick;
		logic [pbfs_pkg::PL_W-1:0] pl;
		logic [pbfs_pkg::FC_W-1:0] fc;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			// Rotate idling: both sides stall, none stalls, only the sink stalls.
			case (phase % 3)
				0: begin
					in_gap_max  = 12;
					out_gap_max = 12;
				end
				1: begin
					in_gap_max  = 0;
					out_gap_max = 0;
				end
				default: begin
					in_gap_max  = 0;
					out_gap_max = 12;
				end
			endcase
			case ($urandom_range(0, 6))
				0: pl = 25'd1;
				1: pl = 25'h1FF_FFFF;
				2: pl = pbfs_pkg::PL_W'($urandom_range(1, 64));
				3: pl = pbfs_pkg::PL_W'($urandom_range(1, 4096));
				4: pl = 25'd0;
				default: pl = pbfs_pkg::PL_W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: fc = 5'd16;
				1: fc = 5'd0;
				2: fc = pbfs_pkg::FC_W'($urandom_range(17, 31));
				default: fc = pbfs_pkg::FC_W'($urandom_range(1, 16));
			endcase
			write_reg(pbfs_pkg::REG_PIECE_LENGTH, pbfs_pkg::CFG_W'(pl));
			write_reg(pbfs_pkg::REG_FILE_COUNT, pbfs_pkg::CFG_W'(fc));
			for (int i = 0; i < MAX_FILES; i++)
				send_item(load_item(4'(i), rand_size()));
			repeat (40) begin
				pick = $urandom_range(0, 19);
				if (pick < 2)
					send_item(load_item(4'($urandom), rand_size()));
				else if (pick == 2)
					send_item(random_request(REQ_NOISE));
				else if (pick == 3)
					send_item(random_request(REQ_OVERRUN));
				else
					send_item(random_request(REQ_WELL));
			end
			sent += MAX_FILES + 40;
			drain();
			phase++;
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = pbfs_pkg::REG_PIECE_LENGTH;
		cfg_data  = '0;
		for (int i = 0; i < MAX_FILES; i++)
			file_size[i] = '0;
		piece_len  = pbfs_pkg::PL_W'(262144);
		files_used = pbfs_pkg::FC_W'(1);
		stream_len = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_segment_walk();
		test_random_traffic();

		if (fail_count == 0 && pending_segments.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
